/* sv/yuv2rgb_pkg.sv */
`timescale 1ns / 1ps
package yuv2rgb_pkg;

    localparam int PIX_W   = 8;
    localparam int FRAC_W  = 16;
    localparam int COEF_W  = 17;
    localparam int DELTA_W = 8;
    localparam int PROD_W  = COEF_W + 1 + DELTA_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int SCL_W   = 2 * PIX_W;

    localparam logic [COEF_W-1:0] COEF_R_V = COEF_W'(89830);
    localparam logic [COEF_W-1:0] COEF_G_V = COEF_W'(45744);
    localparam logic [COEF_W-1:0] COEF_G_U = COEF_W'(22127);
    localparam logic [COEF_W-1:0] COEF_B_U = COEF_W'(113537);

    localparam logic [PIX_W-1:0] CHAN_MAX  = PIX_W'(255);
    localparam logic [PIX_W-1:0] SCALE_MUL = PIX_W'(220);

    localparam int STAGES = 4;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        prod_t r_v;
        prod_t g_v;
        prod_t g_u;
        prod_t b_u;
    } chroma_prod_t;

    typedef struct packed {
        logic sum_en;
        logic clamp_en;
        logic scale_en;
    } pixel_ctrl_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

endpackage

/* sv/yuv2rgb_in_if.sv */
`timescale 1ns / 1ps
interface yuv2rgb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_end;

    modport source (
        output valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end,
        input  ready
    );

    modport sink (
        input  valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end,
        output ready
    );
endinterface

/* sv/yuv2rgb_out_if.sv */
`timescale 1ns / 1ps
interface yuv2rgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_end_out;

    modport source (
        output valid, red_first, green_first, blue_first,
               red_second, green_second, blue_second, frame_end_out,
        input  ready
    );

    modport sink (
        input  valid, red_first, green_first, blue_first,
               red_second, green_second, blue_second, frame_end_out,
        output ready
    );
endinterface

/* sv/yuyv_to_rgb_converter.sv */
`timescale 1ns / 1ps
// YUYV 4:2:2 to RGB888 converter.
// yuyv (sink): one beat carries a packed group Y0, U, Y1, V plus the frame
//   end marker.
// rgb (source): one beat carries two RGB pixels scaled to 0..219 and the
//   frame end marker copied from the matching input beat.
// Four register stages: chroma products, channel sums, clamp, 220/256 scale.
// The scale stage is the output register.
// Throughput: one beat per cycle unless rgb stalls; the stages run in parallel,
//   each limited by one 18x8 multiply or one 27-bit add of up to three terms.
// Each stage holds its beat only while the stage after it is full and
// stalled, so bubbles close up and yuyv.ready stays high until all four
// stages are full behind a stalled receiver. Nothing is dropped or repeated.
// Reset clears the valid bits; the pipeline comes up empty with
// yuyv.ready high.
module yuyv_to_rgb_converter (
    input  logic           clk,
    input  logic           rst_n,
    yuv2rgb_in_if.sink     yuyv,
    yuv2rgb_out_if.source  rgb
);
    import yuv2rgb_pkg::*;

    logic [STAGES-1:0]        valid_reg, valid_next;
    logic [STAGES-1:0]        stage_ready;
    logic [STAGES-1:0]        fend_reg;
    logic [PIX_W-1:0]         y0_reg, y1_reg;
    chroma_prod_t             prod_reg, prod_next;
    logic signed [DELTA_W-1:0] du, dv;
    pixel_ctrl_t              pix_ctrl;
    rgb_t                     rgb_first, rgb_second;

    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || rgb.ready;
        for (int i = STAGES - 2; i >= 0; i--)
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_ready[0])
            valid_next[0] = yuyv.valid;
        for (int i = 1; i < STAGES; i++)
            if (stage_ready[i])
                valid_next[i] = valid_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // C - 128 as a signed byte
    assign du = $signed({~yuyv.chroma_blue[7], yuyv.chroma_blue[6:0]});
    assign dv = $signed({~yuyv.chroma_red[7], yuyv.chroma_red[6:0]});

    always_comb
    begin
        prod_next.r_v = PROD_W'($signed({1'b0, COEF_R_V}) * dv);
        prod_next.g_v = PROD_W'($signed({1'b0, COEF_G_V}) * dv);
        prod_next.g_u = PROD_W'($signed({1'b0, COEF_G_U}) * du);
        prod_next.b_u = PROD_W'($signed({1'b0, COEF_B_U}) * du);
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            y0_reg      <= yuyv.luma_first;
            y1_reg      <= yuyv.luma_second;
            prod_reg    <= prod_next;
            fend_reg[0] <= yuyv.frame_end;
        end
        for (int i = 1; i < STAGES; i++)
            if (stage_ready[i])
                fend_reg[i] <= fend_reg[i-1];
    end

    assign pix_ctrl.sum_en   = stage_ready[1];
    assign pix_ctrl.clamp_en = stage_ready[2];
    assign pix_ctrl.scale_en = stage_ready[3];

    yuv2rgb_pixel u_pixel_first (
        .clk  (clk),
        .luma (y0_reg),
        .prod (prod_reg),
        .ctrl (pix_ctrl),
        .rgb  (rgb_first)
    );

    yuv2rgb_pixel u_pixel_second (
        .clk  (clk),
        .luma (y1_reg),
        .prod (prod_reg),
        .ctrl (pix_ctrl),
        .rgb  (rgb_second)
    );

    assign yuyv.ready        = stage_ready[0];
    assign rgb.valid         = valid_reg[STAGES-1];
    assign rgb.red_first     = rgb_first.red;
    assign rgb.green_first   = rgb_first.green;
    assign rgb.blue_first    = rgb_first.blue;
    assign rgb.red_second    = rgb_second.red;
    assign rgb.green_second  = rgb_second.green;
    assign rgb.blue_second   = rgb_second.blue;
    assign rgb.frame_end_out = fend_reg[STAGES-1];

endmodule

/* sv/yuv2rgb_pixel.sv */
`timescale 1ns / 1ps
module yuv2rgb_pixel (
    input  logic                             clk,
    input  logic [yuv2rgb_pkg::PIX_W-1:0]    luma,
    input  yuv2rgb_pkg::chroma_prod_t        prod,
    input  yuv2rgb_pkg::pixel_ctrl_t         ctrl,
    output yuv2rgb_pkg::rgb_t                rgb
);
    import yuv2rgb_pkg::*;

    sum_t             base;
    sum_t             r_sum_reg, g_sum_reg, b_sum_reg;
    sum_t             r_sum_next, g_sum_next, b_sum_next;
    rgb_t             clamp_reg, clamp_next;
    rgb_t             scale_reg, scale_next;
    logic [SCL_W-1:0] r_scl, g_scl, b_scl;

    function automatic logic [PIX_W-1:0] clamp_chan(input sum_t s);
        logic [PIX_W-1:0] c;
        if (s[SUM_W-1])
            c = '0;
        else if (|s[SUM_W-2:FRAC_W+PIX_W])
            c = CHAN_MAX;
        else
            c = s[FRAC_W+PIX_W-1:FRAC_W];
        return c;
    endfunction

    assign base = $signed({{(SUM_W-PIX_W-FRAC_W){1'b0}}, luma, {FRAC_W{1'b0}}});

    always_comb
    begin
        r_sum_next = base + SUM_W'(prod.r_v);
        g_sum_next = base - SUM_W'(prod.g_v) - SUM_W'(prod.g_u);
        b_sum_next = base + SUM_W'(prod.b_u);
    end

    always_comb
    begin
        clamp_next.red   = clamp_chan(r_sum_reg);
        clamp_next.green = clamp_chan(g_sum_reg);
        clamp_next.blue  = clamp_chan(b_sum_reg);
    end

    // scale by 220/256
    always_comb
    begin
        r_scl            = clamp_reg.red   * SCALE_MUL;
        g_scl            = clamp_reg.green * SCALE_MUL;
        b_scl            = clamp_reg.blue  * SCALE_MUL;
        scale_next.red   = r_scl[SCL_W-1:PIX_W];
        scale_next.green = g_scl[SCL_W-1:PIX_W];
        scale_next.blue  = b_scl[SCL_W-1:PIX_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            r_sum_reg <= r_sum_next;
            g_sum_reg <= g_sum_next;
            b_sum_reg <= b_sum_next;
        end
        if (ctrl.clamp_en)
            clamp_reg <= clamp_next;
        if (ctrl.scale_en)
            scale_reg <= scale_next;
    end

    assign rgb = scale_reg;

endmodule

/* sv/yuv2rgb_checker.sv */
`timescale 1ns / 1ps
module yuv2rgb_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] red_first,
    input  logic [7:0] green_first,
    input  logic [7:0] blue_first,
    input  logic [7:0] red_second,
    input  logic [7:0] green_second,
    input  logic [7:0] blue_second,
    input  logic       frame_end_out
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({red_first, green_first, blue_first,
                        red_second, green_second, blue_second, frame_end_out}))
        else $error("output beat changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> red_first <= 8'd219 && green_first <= 8'd219
            && blue_first <= 8'd219 && red_second <= 8'd219
            && green_second <= 8'd219 && blue_second <= 8'd219)
        else $error("channel above scaled maximum");

    // a ready receiver never backs up the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled with receiver ready");

    // an accepted beat reaches the output when the receiver keeps taking beats
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("beat did not reach output in four cycles");

endmodule

bind yuyv_to_rgb_converter yuv2rgb_checker u_yuv2rgb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (yuyv.valid),
    .in_ready      (yuyv.ready),
    .out_valid     (rgb.valid),
    .out_ready     (rgb.ready),
    .red_first     (rgb.red_first),
    .green_first   (rgb.green_first),
    .blue_first    (rgb.blue_first),
    .red_second    (rgb.red_second),
    .green_second  (rgb.green_second),
    .blue_second   (rgb.blue_second),
    .frame_end_out (rgb.frame_end_out)
);
